// ===== hw/rtl/bblce_pkg.sv =====
// bblce_pkg: shared payload types, register codes and constants of the
// line box filter. No dependencies.
package bblce_pkg;

  localparam int NUM_CH          = 4;
  localparam int CH_W            = 16;
  localparam int RADIUS_BITS     = 6;
  localparam int LINE_WIDTH_BITS = 13;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_MAX = 2'd2;

  localparam int              RST_RADIUS      = 1;
  localparam int              RST_LINE_WIDTH  = 4096;
  localparam logic [CH_W-1:0] RST_CHANNEL_MAX = 16'd255;

  // most outputs one line-ending request may flush
  localparam int MAX_FLUSH = 64;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] alpha_in;
  } in_pix_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] alpha_out;
    logic            line_end;
  } out_pix_t;

endpackage

// ===== hw/rtl/bblce_front.sv =====
// bblce_front: accepts pixels, writes the pixel ring and makes an output
// job (one output or a line flush) when due. Depends on bblce_pkg.
module bblce_front #(
  parameter int  CB      = 16,
  parameter int  POS_W   = 12,
  parameter int  RAD_W   = 6,
  parameter int  RING_AW = 8,
  parameter type job_t   = logic
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bblce_pkg::in_pix_t              in_data,
  input  logic [RAD_W-1:0]                radius,
  input  logic [POS_W-1:0]                wlast,
  input  logic                            oldest_valid,
  input  logic [RING_AW-1:0]              oldest_addr,
  input  logic                            job_full,
  output logic                            job_push,
  output job_t                            job,
  output logic                            wr_en,
  output logic [RING_AW-1:0]              wr_addr,
  output logic [bblce_pkg::NUM_CH-1:0][CB-1:0] wr_data
);
  import bblce_pkg::*;

  logic [POS_W-1:0]             in_pos_r, in_pos_nxt;
  logic [POS_W-1:0]             out_pos_r, out_pos_nxt;
  logic [RING_AW-1:0]           wr_ptr_r;
  logic [NUM_CH-1:0][CB-1:0]    first_r;
  logic [RING_AW-1:0]           lead;
  logic [POS_W-1:0]             lag;
  logic                         accept;
  logic                         flush;
  logic                         emit_one;

  assign wr_data[0] = in_data.red_in[CB-1:0];
  assign wr_data[1] = in_data.green_in[CB-1:0];
  assign wr_data[2] = in_data.blue_in[CB-1:0];
  assign wr_data[3] = in_data.alpha_in[CB-1:0];

  // keep the write pointer less than half a ring ahead of the oldest job
  assign lead     = wr_ptr_r - oldest_addr;
  assign in_ready = !job_full && !(oldest_valid && lead[RING_AW-1]);
  assign accept   = in_valid && in_ready;

  assign wr_en   = accept;
  assign wr_addr = wr_ptr_r;

  assign flush    = in_pos_r >= wlast;
  assign lag      = in_pos_r - out_pos_r;
  assign emit_one = (32'(out_pos_r) + 32'(radius)) <= 32'(in_pos_r);
  assign job_push = accept && (flush || emit_one);

  always_comb begin
    job.first     = (in_pos_r == '0) ? wr_data : first_r;
    job.i_start   = out_pos_r;
    job.edge_pos  = in_pos_r;
    job.edge_addr = wr_ptr_r;
    job.radius    = radius;
    if (!flush) begin
      job.i_last = out_pos_r;
    end else if (32'(lag) >= MAX_FLUSH) begin
      job.i_last = out_pos_r + POS_W'(MAX_FLUSH - 1);
    end else begin
      job.i_last = in_pos_r;
    end
  end

  always_comb begin
    in_pos_nxt  = in_pos_r;
    out_pos_nxt = out_pos_r;
    if (accept) begin
      if (flush) begin
        in_pos_nxt  = '0;
        out_pos_nxt = '0;
      end else begin
        in_pos_nxt = in_pos_r + 1'b1;
        if (emit_one) begin
          out_pos_nxt = out_pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pos_r  <= '0;
      out_pos_r <= '0;
      wr_ptr_r  <= '0;
    end else begin
      in_pos_r  <= in_pos_nxt;
      out_pos_r <= out_pos_nxt;
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_pos_r == '0) begin
      first_r <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/bblce_job_fifo.sv =====
// bblce_job_fifo: short queue of output jobs between front and back.
// Generic over the job type; no package dependency.
module bblce_job_fifo #(
  parameter type job_t = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign head  = mem_r[rd_ptr_r];
  assign empty = cnt_r == '0;
  assign full  = cnt_r == CW'(DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/bblce_div.sv =====
// bblce_div: four-lane restoring divider, one quotient bit per cycle.
// Divides window sums by the window length. Depends on bblce_pkg.
module bblce_div #(
  parameter int CB    = 16,
  parameter int WIN_W = 7
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  input  logic [bblce_pkg::NUM_CH-1:0][CB+WIN_W-1:0]  dividend,
  input  logic [WIN_W-1:0]                            divisor,
  output logic                                        busy,
  output logic [bblce_pkg::NUM_CH-1:0][CB-1:0]        quot
);
  import bblce_pkg::*;

  localparam int CNT_W = $clog2(CB + 1);

  logic                          busy_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [WIN_W-1:0]              win_r;
  logic [NUM_CH-1:0][WIN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_CH-1:0][CB-1:0]     lo_r, lo_nxt;
  logic [NUM_CH-1:0][WIN_W:0]    trial;
  logic [NUM_CH-1:0]             ge;

  // quotient is known to fit CB bits, so the top bits seed the remainder
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      trial[c]   = {rem_r[c], lo_r[c][CB-1]};
      ge[c]      = trial[c] >= {1'b0, win_r};
      rem_nxt[c] = ge[c] ? WIN_W'(trial[c] - {1'b0, win_r}) : trial[c][WIN_W-1:0];
      lo_nxt[c]  = {lo_r[c][CB-2:0], ge[c]};
    end
  end

  assign busy = busy_r;
  assign quot = lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(CB);
    end else if (busy_r) begin
      busy_r <= cnt_r != CNT_W'(1);
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      win_r <= divisor;
      for (int c = 0; c < NUM_CH; c++) begin
        rem_r[c] <= dividend[c][CB+WIN_W-1:CB];
        lo_r[c]  <= dividend[c][CB-1:0];
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
    end
  end

endmodule

// ===== hw/rtl/bblce_back.sv =====
// bblce_back: pixel ring memory, window summation over the ring, division
// and the output register. Depends on bblce_pkg and bblce_div.
module bblce_back #(
  parameter int  CB      = 16,
  parameter int  POS_W   = 12,
  parameter int  RAD_W   = 6,
  parameter int  RING_AW = 8,
  parameter int  K_W     = 14,
  parameter int  WIN_W   = 7,
  parameter type job_t   = logic
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  job_valid,
  input  job_t                                  job_head,
  output logic                                  job_pop,
  input  logic                                  wr_en,
  input  logic [RING_AW-1:0]                    wr_addr,
  input  logic [bblce_pkg::NUM_CH-1:0][CB-1:0]  wr_data,
  input  logic [bblce_pkg::CH_W-1:0]            channel_max,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output bblce_pkg::out_pix_t                   out_data,
  output logic                                  busy,
  output logic [RING_AW-1:0]                    cur_addr
);
  import bblce_pkg::*;

  localparam int SUM_W  = CB + WIN_W;
  localparam int RING_D = 2 ** RING_AW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  localparam logic signed [K_W-1:0] K_ONE = 1;

  logic [NUM_CH-1:0][CB-1:0]     ring_mem [RING_D];
  logic [NUM_CH-1:0][CB-1:0]     ring_q_r;

  logic [2:0]                    state_r, state_nxt;
  job_t                          job_r;
  logic [POS_W-1:0]              i_r, i_nxt;
  logic signed [K_W-1:0]         k_r, k_nxt;
  logic                          take_r;
  logic                          first_sel_r;
  logic [NUM_CH-1:0][SUM_W-1:0]  sum_r;
  logic                          out_valid_r;
  out_pix_t                      out_data_r, out_data_nxt;

  logic signed [K_W-1:0]         kedge, kend, kc, back_off;
  logic [RING_AW-1:0]            rd_addr;
  logic                          rd_en;
  logic                          clr_sum;
  logic                          load_out;
  logic                          div_start;
  logic                          div_busy;
  logic [NUM_CH-1:0][CB-1:0]     div_q;
  logic [NUM_CH-1:0][CH_W-1:0]   clamped;
  logic                          out_free;
  logic [POS_W-1:0]              i_inc;

  assign busy     = state_r != S_IDLE;
  assign cur_addr = job_r.edge_addr;

  // window position to ring address; beyond the edge reads the edge pixel
  assign kedge    = $signed(K_W'(job_r.edge_pos));
  assign kend     = $signed(K_W'(i_r) + K_W'(job_r.radius));
  assign kc       = (k_r > kedge) ? kedge : k_r;
  assign back_off = kedge - kc;
  assign rd_addr  = job_r.edge_addr - RING_AW'(back_off);
  assign rd_en    = state_r == S_SUM;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ring_q_r <= ring_mem[rd_addr];
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign i_inc    = i_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    job_pop   = 1'b0;
    clr_sum   = 1'b0;
    load_out  = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          clr_sum   = 1'b1;
          i_nxt     = job_head.i_start;
          k_nxt     = K_W'(job_head.i_start) - K_W'(job_head.radius);
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        k_nxt = k_r + K_ONE;
        if (k_r == kend) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_DIVGO;
      S_DIVGO: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          if (i_r == job_r.i_last) begin
            state_nxt = S_IDLE;
          end else begin
            clr_sum   = 1'b1;
            i_nxt     = i_inc;
            k_nxt     = K_W'(i_inc) - K_W'(job_r.radius);
            state_nxt = S_SUM;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      take_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      take_r  <= rd_en;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    k_r         <= k_nxt;
    first_sel_r <= k_r < K_ONE;
    if (job_pop) begin
      job_r <= job_head;
    end
    if (clr_sum) begin
      sum_r <= '0;
    end else if (take_r) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sum_r[c] <= sum_r[c] + SUM_W'(first_sel_r ? job_r.first[c] : ring_q_r[c]);
      end
    end
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  bblce_div #(
    .CB    (CB),
    .WIN_W (WIN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  ({job_r.radius, 1'b1}),
    .busy     (div_busy),
    .quot     (div_q)
  );

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      clamped[c] = (CH_W'(div_q[c]) > channel_max) ? channel_max : CH_W'(div_q[c]);
    end
    out_data_nxt.red_out   = clamped[0];
    out_data_nxt.green_out = clamped[1];
    out_data_nxt.blue_out  = clamped[2];
    out_data_nxt.alpha_out = clamped[3];
    out_data_nxt.line_end  = i_r == job_r.edge_pos;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/box_blur_line_clamped_edges.sv =====
// box_blur_line_clamped_edges: top level of the line box filter, config
// registers and the front / job queue / back chain.
// Depends on bblce_pkg, bblce_front, bblce_job_fifo, bblce_back, bblce_div.
//
// Usage: one line of ARGB pixels enters on the in_ channel, one pixel per
// request, in line order. Each output pixel is the per-channel floor average
// of the 2r+1 neighbors, edge pixels repeated past both ends, limited to
// channel_max. Outputs trail the inputs by r pixels; the line's last pixel
// releases every output still owed, the final one with line_end set.
// Configuration (radius, line width, channel max) is written on the cfg_
// port while the block is idle.
// Each output pixel takes the back end one ring read per window tap, then
// one quotient bit per cycle in the divider. The front takes a new pixel
// each cycle while the two-entry job queue has room and the pixel ring is
// less than half a ring ahead of the oldest pending job.
// Reset clears positions, queue and output valid; ring contents need none.
// A stalled receiver holds the output register, then the back end, then
// the queue, and finally in_ready drops.
module box_blur_line_clamped_edges #(
  parameter int MAX_RADIUS     = 63,
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int CHANNEL_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bblce_pkg::in_pix_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bblce_pkg::out_pix_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [bblce_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bblce_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bblce_pkg::*;

  localparam int CB        = CHANNEL_BITS;
  localparam int POS_W     = $clog2(MAX_LINE_WIDTH);
  localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
  localparam int WIN_W     = RAD_W + 1;
  localparam int RING_AW   = $clog2(4 * MAX_RADIUS);
  localparam int K_W       = ((POS_W > RAD_W) ? POS_W : RAD_W) + 2;
  localparam int JOB_DEPTH = 2;
  localparam int WLAST_RST =
    ((RST_LINE_WIDTH > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : RST_LINE_WIDTH) - 1;

  typedef struct packed {
    logic [NUM_CH-1:0][CB-1:0] first;
    logic [POS_W-1:0]          i_start;
    logic [POS_W-1:0]          i_last;
    logic [POS_W-1:0]          edge_pos;
    logic [RING_AW-1:0]        edge_addr;
    logic [RAD_W-1:0]          radius;
  } job_t;

  logic [RAD_W-1:0]           radius_r;
  logic [POS_W-1:0]           wlast_r;
  logic [CH_W-1:0]            cmax_r;
  logic [RAD_W-1:0]           radius_wr;
  logic [POS_W-1:0]           wlast_wr;
  logic [RADIUS_BITS-1:0]     radius_raw;
  logic [LINE_WIDTH_BITS-1:0] width_raw;

  logic                       job_push;
  logic                       job_pop;
  logic                       job_full;
  logic                       job_empty;
  job_t                       job_new;
  job_t                       job_head;
  logic                       back_busy;
  logic [RING_AW-1:0]         back_addr;
  logic                       oldest_valid;
  logic [RING_AW-1:0]         oldest_addr;
  logic                       wr_en;
  logic [RING_AW-1:0]         wr_addr;
  logic [NUM_CH-1:0][CB-1:0]  wr_data;

  // registers hold effective values: radius clamped, line width as last index
  assign radius_raw = cfg_wdata[RADIUS_BITS-1:0];
  assign width_raw  = cfg_wdata[LINE_WIDTH_BITS-1:0];

  always_comb begin
    if (radius_raw == '0) begin
      radius_wr = RAD_W'(1);
    end else if (32'(radius_raw) > MAX_RADIUS) begin
      radius_wr = RAD_W'(MAX_RADIUS);
    end else begin
      radius_wr = RAD_W'(radius_raw);
    end
    if (width_raw == '0) begin
      wlast_wr = '0;
    end else if (32'(width_raw) >= MAX_LINE_WIDTH) begin
      wlast_wr = POS_W'(MAX_LINE_WIDTH - 1);
    end else begin
      wlast_wr = POS_W'(width_raw - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(RST_RADIUS);
      wlast_r  <= POS_W'(WLAST_RST);
      cmax_r   <= RST_CHANNEL_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS:      radius_r <= radius_wr;
        CFG_LINE_WIDTH:  wlast_r  <= wlast_wr;
        CFG_CHANNEL_MAX: cmax_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign oldest_valid = back_busy || !job_empty;
  assign oldest_addr  = back_busy ? back_addr : job_head.edge_addr;

  bblce_front #(
    .CB      (CB),
    .POS_W   (POS_W),
    .RAD_W   (RAD_W),
    .RING_AW (RING_AW),
    .job_t   (job_t)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .radius       (radius_r),
    .wlast        (wlast_r),
    .oldest_valid (oldest_valid),
    .oldest_addr  (oldest_addr),
    .job_full     (job_full),
    .job_push     (job_push),
    .job          (job_new),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  bblce_job_fifo #(
    .job_t (job_t),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_new),
    .pop       (job_pop),
    .head      (job_head),
    .empty     (job_empty),
    .full      (job_full)
  );

  bblce_back #(
    .CB      (CB),
    .POS_W   (POS_W),
    .RAD_W   (RAD_W),
    .RING_AW (RING_AW),
    .K_W     (K_W),
    .WIN_W   (WIN_W),
    .job_t   (job_t)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (!job_empty),
    .job_head    (job_head),
    .job_pop     (job_pop),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .channel_max (cmax_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .busy        (back_busy),
    .cur_addr    (back_addr)
  );

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("job popped from an empty queue");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> back_busy)
    else $error("back end idle after taking a job");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== dv/bblce_line_checker.sv =====
// bblce_line_checker: watches the pixel, result and register ports of the line
// box filter, predicts every output pixel and compares it field by field.
// Depends on bblce_pkg.
module bblce_line_checker #(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  bblce_pkg::in_pix_t                in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  bblce_pkg::out_pix_t               out_data,
  input  logic                              cfg_we,
  input  logic [bblce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bblce_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                fail_count,
  output int                                owed
);
  import bblce_pkg::*;

  localparam int RING_DEPTH = 128;

  logic [RADIUS_BITS-1:0]     radius_q;
  logic [LINE_WIDTH_BITS-1:0] width_q;
  logic [CH_W-1:0]            cmax_q;

  in_pix_t  ring_px [RING_DEPTH];
  in_pix_t  first_px;
  int       in_pos;
  int       out_pos;
  out_pix_t owed_pix [$];

  task automatic flag_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  // Window tap at a line position; left of the line is pixel 0, right of the
  // newest pixel is the newest pixel.
  function automatic in_pix_t tap_pixel(input int pos, input int last_pos);
    if (pos <= 0) return first_px;
    if (pos > last_pos) pos = last_pos;
    return ring_px[pos % RING_DEPTH];
  endfunction

  function automatic out_pix_t box_average(input int center, input int last_pos,
                                           input int rad, input bit fin);
    int unsigned sr, sg, sb, sa, win;
    int          k;
    in_pix_t     p;
    out_pix_t    o;
    sr = 0;
    sg = 0;
    sb = 0;
    sa = 0;
    win = 2 * rad + 1;
    for (k = center - rad; k <= center + rad; k++) begin
      p = tap_pixel(k, last_pos);
      sr += p.red_in;
      sg += p.green_in;
      sb += p.blue_in;
      sa += p.alpha_in;
    end
    sr = sr / win;
    sg = sg / win;
    sb = sb / win;
    sa = sa / win;
    o.red_out   = (sr > cmax_q) ? cmax_q : CH_W'(sr);
    o.green_out = (sg > cmax_q) ? cmax_q : CH_W'(sg);
    o.blue_out  = (sb > cmax_q) ? cmax_q : CH_W'(sb);
    o.alpha_out = (sa > cmax_q) ? cmax_q : CH_W'(sa);
    o.line_end  = fin;
    return o;
  endfunction

  task automatic take_pixel(input in_pix_t px);
    int rad, wid, j, i, n;
    rad = (radius_q == 0) ? 1 : int'(radius_q);
    wid = int'(width_q);
    if (wid < 1) wid = 1;
    if (wid > MAX_LINE_WIDTH) wid = MAX_LINE_WIDTH;
    j = in_pos;
    ring_px[j % RING_DEPTH] = px;
    if (j == 0) first_px = px;
    if (j >= wid - 1) begin
      n = 0;
      for (i = out_pos; i <= j && n < MAX_FLUSH; i++) begin
        owed_pix.push_back(box_average(i, j, rad, i == j));
        n++;
      end
      in_pos  = 0;
      out_pos = 0;
    end else begin
      if (out_pos + rad <= j) begin
        owed_pix.push_back(box_average(out_pos, j, rad, 1'b0));
        out_pos++;
      end
      in_pos = j + 1;
    end
  endtask

  always @(posedge clk) begin : watch
    out_pix_t want;
    if (!rst_n) begin
      radius_q = RADIUS_BITS'(RST_RADIUS);
      width_q  = LINE_WIDTH_BITS'(RST_LINE_WIDTH);
      cmax_q   = RST_CHANNEL_MAX;
      first_px = '0;
      in_pos   = 0;
      out_pos  = 0;
      owed_pix.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIUS:      radius_q = cfg_wdata[RADIUS_BITS-1:0];
          CFG_LINE_WIDTH:  width_q  = cfg_wdata[LINE_WIDTH_BITS-1:0];
          CFG_CHANNEL_MAX: cmax_q   = cfg_wdata[CH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_pixel(in_data);
      if (out_valid && out_ready) begin
        if (owed_pix.size() == 0) begin
          flag_mismatch("output pixel with none owed", int'(out_data.red_out), 0);
        end else begin
          want = owed_pix.pop_front();
          if (out_data.red_out !== want.red_out)
            flag_mismatch("red_out", int'(out_data.red_out), int'(want.red_out));
          if (out_data.green_out !== want.green_out)
            flag_mismatch("green_out", int'(out_data.green_out), int'(want.green_out));
          if (out_data.blue_out !== want.blue_out)
            flag_mismatch("blue_out", int'(out_data.blue_out), int'(want.blue_out));
          if (out_data.alpha_out !== want.alpha_out)
            flag_mismatch("alpha_out", int'(out_data.alpha_out), int'(want.alpha_out));
          if (out_data.line_end !== want.line_end)
            flag_mismatch("line_end", int'(out_data.line_end), int'(want.line_end));
        end
      end
    end
    owed <= owed_pix.size();
  end

endmodule

// ===== dv/box_blur_line_clamped_edges_test.sv =====
// box_blur_line_clamped_edges_test: stimulus and verdict for the line box filter.
// Drives lines of pixels under changing register settings and idle patterns;
// depends on bblce_pkg, the block and bblce_line_checker.
module box_blur_line_clamped_edges_test;
  import bblce_pkg::*;

  localparam int SETTLE     = 4 * (2 * 63 + CH_W + 6);
  localparam int QUIET_MAX  = 20000;
  localparam int HOLD_LEN   = 1500;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_pix_t                in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_pix_t               out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int                     fail_count;
  int                     owed;

  int tx_idle;
  int rx_idle;
  int rx_hold_req;
  int hold_left;
  bit hold_taken;
  int quiet;

  box_blur_line_clamped_edges u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bblce_line_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .owed       (owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_ready  = 1'b0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0 && !hold_taken) begin
        hold_left  = rx_hold_req;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  initial begin
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL box_blur_line_clamped_edges");
    $finish;
  end

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1:       return CH_W'($urandom_range(0, 255));
      default: return CH_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic in_pix_t rand_pixel();
    in_pix_t p;
    p.red_in   = rand_chan();
    p.green_in = rand_chan();
    p.blue_in  = rand_chan();
    p.alpha_in = rand_chan();
    return p;
  endfunction

  function automatic in_pix_t mk_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                       input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
    in_pix_t p;
    p.red_in   = r;
    p.green_in = g;
    p.blue_in  = b;
    p.alpha_in = a;
    return p;
  endfunction

  task automatic offer_pixel(input in_pix_t p);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop the request, wait for every owed pixel, then let the pipe go quiet
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int quota);
    int sent, wid, rad, cut, k;
    logic [CFG_DATA_W-1:0] val;
    sent = 0;
    while (sent < quota) begin
      case ($urandom_range(0, 9))
        0, 1:    rad = $urandom_range(0, 15);
        2:       rad = $urandom_range(16, 63);
        default: rad = $urandom_range(1, 4);
      endcase
      wid = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
      wait_results_drained();
      val = CFG_DATA_W'($urandom);
      val[RADIUS_BITS-1:0] = RADIUS_BITS'(rad);
      write_reg(CFG_RADIUS, val);
      val = CFG_DATA_W'($urandom);
      val[LINE_WIDTH_BITS-1:0] = LINE_WIDTH_BITS'(wid);
      write_reg(CFG_LINE_WIDTH, val);
      case ($urandom_range(0, 7))
        0, 1:    val = 16'd255;
        2:       val = 16'd32768;
        3, 4:    val = 16'hFFFF;
        7:       val = 16'd0;
        default: val = CFG_DATA_W'($urandom_range(1, 65535));
      endcase
      write_reg(CFG_CHANNEL_MAX, val);
      if (wid < 1) wid = 1;
      cut = (wid >= 4 && $urandom_range(0, 5) == 0) ? $urandom_range(1, wid - 1) : wid;
      for (k = 0; k < cut; k++) offer_pixel(rand_pixel());
      if (cut < wid) begin
        // radius change partway through the line
        wait_results_drained();
        write_reg(CFG_RADIUS, CFG_DATA_W'($urandom));
        for (k = cut; k < wid; k++) offer_pixel(rand_pixel());
      end
      sent += wid;
    end
  endtask

  initial begin : stimulus
    int k;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_RADIUS;
    cfg_wdata   = '0;
    tx_idle     = 19;
    rx_idle     = 88;
    rx_hold_req = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: radius 1, clamp 255, line ended early by a zero width
    offer_pixel(mk_pixel(16'd10, 16'd20, 16'd30, 16'd40));
    offer_pixel(mk_pixel(16'd300, 16'd255, 16'd0, 16'hFFFF));
    offer_pixel(mk_pixel(16'hFFFF, 16'd1, 16'd254, 16'd256));
    wait_results_drained();
    write_reg(CFG_LINE_WIDTH, 16'd0);
    offer_pixel(mk_pixel(16'd7, 16'd8, 16'd9, 16'd10));

    // zero radius, one-pixel lines, full clamp range
    wait_results_drained();
    write_reg(CFG_RADIUS, 16'd0);
    write_reg(CFG_LINE_WIDTH, 16'd1);
    write_reg(CFG_CHANNEL_MAX, 16'hFFFF);
    offer_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000));

    // widest window on a three-pixel line, clamp to zero
    wait_results_drained();
    write_reg(CFG_RADIUS, 16'd63);
    write_reg(CFG_LINE_WIDTH, 16'd3);
    write_reg(CFG_CHANNEL_MAX, 16'd0);
    offer_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer_pixel(mk_pixel(16'h8000, 16'h0001, 16'h7FFF, 16'hAAAA));
    offer_pixel(mk_pixel(16'h0001, 16'h5555, 16'h0000, 16'hFFFF));

    // upper data bits ignored, unused index ignored
    wait_results_drained();
    write_reg(CFG_RADIUS, 16'hFFC2);
    write_reg(CFG_LINE_WIDTH, 16'hE005);
    write_reg(CFG_CHANNEL_MAX, 16'd255);
    write_reg(CFG_UNUSED, 16'hFFFF);
    for (k = 0; k < 5; k++) offer_pixel(rand_pixel());

    // oversized width, then radius and width changed partway through
    wait_results_drained();
    write_reg(CFG_RADIUS, 16'd3);
    write_reg(CFG_LINE_WIDTH, 16'h1FFF);
    write_reg(CFG_CHANNEL_MAX, 16'hFFFF);
    for (k = 0; k < 8; k++) offer_pixel(rand_pixel());
    wait_results_drained();
    write_reg(CFG_RADIUS, 16'd1);
    for (k = 0; k < 3; k++) offer_pixel(rand_pixel());
    wait_results_drained();
    write_reg(CFG_LINE_WIDTH, 16'd1);
    offer_pixel(rand_pixel());

    run_random(32);
    tx_idle = 88;
    rx_idle = 19;
    run_random(32);
    tx_idle = 0;
    rx_idle = 0;

    // receiver holds off while a long line keeps coming
    wait_results_drained();
    write_reg(CFG_RADIUS, 16'd2);
    write_reg(CFG_LINE_WIDTH, 16'd40);
    write_reg(CFG_CHANNEL_MAX, 16'hFFFF);
    rx_hold_req = HOLD_LEN;
    for (k = 0; k < 40; k++) offer_pixel(rand_pixel());

    run_random(32);
    wait_results_drained();

    if (fail_count == 0 && owed == 0) begin
      $display("PASS box_blur_line_clamped_edges");
    end else begin
      $display("FAIL box_blur_line_clamped_edges");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bblce_pkg.sv
hw/rtl/bblce_front.sv
hw/rtl/bblce_job_fifo.sv
hw/rtl/bblce_div.sv
hw/rtl/bblce_back.sv
hw/rtl/box_blur_line_clamped_edges.sv
dv/bblce_line_checker.sv
dv/box_blur_line_clamped_edges_test.sv
